[src/telemetry_packet_unpacker_assert.svh]
// Assertion macros for the telemetry packet unpacker.
`ifndef TELEMETRY_PACKET_UNPACKER_ASSERT_SVH
`define TELEMETRY_PACKET_UNPACKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TPU_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define TPU_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[src/tpu_pkg.sv]
// Shared types and constants for the telemetry packet unpacker.
package tpu_pkg;

   localparam int COUNT_WIDTH        = 8;
   localparam int KEEP_BYTES         = 18;
   localparam int INDEX_WIDTH        = $clog2(KEEP_BYTES);
   localparam int FULL_LEN           = 18;
   localparam int SHORT_LEN          = 14;
   localparam int MIN_LEN            = 9;
   localparam int PACKED_SENSOR_BASE = 6;
   localparam int NUM_SENSORS        = 5;
   localparam int ADDR_WIDTH         = 48;
   localparam logic [ADDR_WIDTH-1:0] SENDER_RESET = 48'hAC276ECC25B0;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_WRONG_SOURCE = 2'd1,
      STATUS_TOO_SHORT    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      LAYOUT_FULL,
      LAYOUT_SHORT,
      LAYOUT_PACKED
   } layout_type;

   typedef logic [KEEP_BYTES-1:0][7:0] byte_array_type;

   // What the capture side knows about a finished packet
   typedef struct packed {
      status_type             status;
      layout_type             layout;
      logic [NUM_SENSORS-1:0] reach;
   } pkt_info_type;

endpackage

[src/telemetry_packet_unpacker.sv]
// Telemetry packet unpacker: one byte item per cycle while not stalled, one result per packet.
// Throughput: one byte item per cycle, except while a finished packet waits on a stalled result.
// A finished packet passes through the capture register, then the result register, before
// its result can be taken.
// Reset (synchronous, active high): count cleared, no packet pending, no result
// valid, expected sender back to its default; the byte store is not cleared.
module telemetry_packet_unpacker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [tpu_pkg::ADDR_WIDTH-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last_byte,
   input  logic [tpu_pkg::ADDR_WIDTH-1:0] req_sender_address,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [15:0]             rsp_left_speed,
   output logic signed [7:0]              rsp_left_direction,
   output logic signed [15:0]             rsp_right_speed,
   output logic signed [7:0]              rsp_right_direction,
   output logic                           rsp_sensor_a,
   output logic                           rsp_sensor_b,
   output logic                           rsp_sensor_c,
   output logic                           rsp_sensor_d,
   output logic                           rsp_sensor_e,
   output logic [1:0]                     rsp_packet_status
);

`include "telemetry_packet_unpacker_assert.svh"

   logic                    pkt_valid;
   logic                    pkt_take;
   tpu_pkg::pkt_info_type   pkt_info;
   tpu_pkg::byte_array_type pkt_bytes;

   tpu_capture u_capture (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_sender_address (req_sender_address),
      .pkt_take           (pkt_take),
      .pkt_valid          (pkt_valid),
      .pkt_info           (pkt_info),
      .pkt_bytes          (pkt_bytes)
   );

   tpu_unpack u_unpack (
      .clock               (clock),
      .reset               (reset),
      .pkt_valid           (pkt_valid),
      .pkt_info            (pkt_info),
      .pkt_bytes           (pkt_bytes),
      .pkt_take            (pkt_take),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_speed      (rsp_left_speed),
      .rsp_left_direction  (rsp_left_direction),
      .rsp_right_speed     (rsp_right_speed),
      .rsp_right_direction (rsp_right_direction),
      .rsp_sensor_a        (rsp_sensor_a),
      .rsp_sensor_b        (rsp_sensor_b),
      .rsp_sensor_c        (rsp_sensor_c),
      .rsp_sensor_d        (rsp_sensor_d),
      .rsp_sensor_e        (rsp_sensor_e),
      .rsp_packet_status   (rsp_packet_status)
   );

   // a held packet must not let new bytes overwrite the store
   `TPU_ASSERT_SAME(a_stall_blocks_input, clock, reset,
      pkt_valid && rsp_valid && !rsp_ready, !req_ready, "input taken while packet held")

   `TPU_ASSERT_NEXT(a_last_sets_pending, clock, reset,
      req_valid && req_ready && req_last_byte, pkt_valid, "last item left no packet")

   `TPU_ASSERT_SAME(a_reject_zero, clock, reset,
      rsp_valid && (rsp_packet_status != tpu_pkg::STATUS_OK),
      (rsp_left_speed == 16'sd0) && (rsp_right_speed == 16'sd0) &&
      (rsp_left_direction == 8'sd0) && (rsp_right_direction == 8'sd0) &&
      !(rsp_sensor_a || rsp_sensor_b || rsp_sensor_c || rsp_sensor_d || rsp_sensor_e),
      "rejected packet carries data")

endmodule

[src/tpu_capture.sv]
// Byte counting, byte store, sender check and finished-packet holding register.
module tpu_capture (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [tpu_pkg::ADDR_WIDTH-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_last_byte,
   input  logic [tpu_pkg::ADDR_WIDTH-1:0]   req_sender_address,
   input  logic                             pkt_take,
   output logic                             pkt_valid,
   output tpu_pkg::pkt_info_type            pkt_info,
   output tpu_pkg::byte_array_type          pkt_bytes
);

   logic [tpu_pkg::ADDR_WIDTH-1:0]  sender_ff, sender_in;
   logic [tpu_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [tpu_pkg::COUNT_WIDTH-1:0] len;
   tpu_pkg::byte_array_type         bytes_ff, bytes_in;
   logic                            pend_ff, pend_in;
   tpu_pkg::pkt_info_type           info_ff, info_in;
   logic                            accept;

   assign req_ready = !pend_ff || pkt_take;
   assign accept    = req_valid && req_ready;

   // length including this byte, held at the counter's top value
   assign len = (count_ff == {tpu_pkg::COUNT_WIDTH{1'b1}}) ? count_ff
                : count_ff + tpu_pkg::COUNT_WIDTH'(1);

   always_comb begin
      sender_in = csr_write_enable ? csr_write_data : sender_ff;

      count_in = count_ff;
      bytes_in = bytes_ff;
      if (accept) begin
         count_in = req_last_byte ? '0 : len;
         if (count_ff < tpu_pkg::COUNT_WIDTH'(tpu_pkg::KEEP_BYTES)) begin
            bytes_in[count_ff[tpu_pkg::INDEX_WIDTH-1:0]] = req_data_byte;
         end
      end

      pend_in = pend_ff;
      if (accept && req_last_byte) begin
         pend_in = 1'b1;
      end else if (pkt_take) begin
         pend_in = 1'b0;
      end

      info_in = info_ff;
      if (accept && req_last_byte) begin
         if (req_sender_address != sender_ff) begin
            info_in.status = tpu_pkg::STATUS_WRONG_SOURCE;
         end else if (len < tpu_pkg::COUNT_WIDTH'(tpu_pkg::MIN_LEN)) begin
            info_in.status = tpu_pkg::STATUS_TOO_SHORT;
         end else begin
            info_in.status = tpu_pkg::STATUS_OK;
         end
         if (len == tpu_pkg::COUNT_WIDTH'(tpu_pkg::FULL_LEN)) begin
            info_in.layout = tpu_pkg::LAYOUT_FULL;
         end else if (len == tpu_pkg::COUNT_WIDTH'(tpu_pkg::SHORT_LEN)) begin
            info_in.layout = tpu_pkg::LAYOUT_SHORT;
         end else begin
            info_in.layout = tpu_pkg::LAYOUT_PACKED;
         end
         // packed layout: a sensor byte counts only if the packet reached it
         for (int j = 0; j < tpu_pkg::NUM_SENSORS; j++) begin
            info_in.reach[j] = len > tpu_pkg::COUNT_WIDTH'(tpu_pkg::PACKED_SENSOR_BASE + j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sender_ff <= tpu_pkg::SENDER_RESET;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
      end else begin
         sender_ff <= sender_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      info_ff  <= info_in;
   end

   assign pkt_valid = pend_ff;
   assign pkt_info  = info_ff;
   assign pkt_bytes = bytes_ff;

endmodule

[src/tpu_unpack.sv]
// Layout decode of a finished packet and the result register.
module tpu_unpack (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pkt_valid,
   input  tpu_pkg::pkt_info_type   pkt_info,
   input  tpu_pkg::byte_array_type pkt_bytes,
   output logic                    pkt_take,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [15:0]      rsp_left_speed,
   output logic signed [7:0]       rsp_left_direction,
   output logic signed [15:0]      rsp_right_speed,
   output logic signed [7:0]       rsp_right_direction,
   output logic                    rsp_sensor_a,
   output logic                    rsp_sensor_b,
   output logic                    rsp_sensor_c,
   output logic                    rsp_sensor_d,
   output logic                    rsp_sensor_e,
   output logic [1:0]              rsp_packet_status
);

   logic                                valid_ff, valid_in;
   logic [15:0]                         lspeed_ff, lspeed_in;
   logic [7:0]                          ldir_ff, ldir_in;
   logic [15:0]                         rspeed_ff, rspeed_in;
   logic [7:0]                          rdir_ff, rdir_in;
   logic [tpu_pkg::NUM_SENSORS-1:0]     sens_ff, sens_in;
   tpu_pkg::status_type                 status_ff, status_in;
   tpu_pkg::byte_array_type             b;

   assign b        = pkt_bytes;
   assign pkt_take = pkt_valid && (!valid_ff || rsp_ready);

   always_comb begin
      lspeed_in = '0;
      ldir_in   = '0;
      rspeed_in = '0;
      rdir_in   = '0;
      sens_in   = '0;
      unique case (pkt_info.layout)
         tpu_pkg::LAYOUT_FULL, tpu_pkg::LAYOUT_SHORT: begin
            lspeed_in  = {b[1], b[0]};
            ldir_in    = b[2];
            rspeed_in  = {b[5], b[4]};
            rdir_in    = b[6];
            sens_in[0] = |{b[9], b[8]};
            sens_in[1] = |{b[11], b[10]};
            sens_in[2] = |{b[13], b[12]};
            if (pkt_info.layout == tpu_pkg::LAYOUT_FULL) begin
               sens_in[3] = |{b[15], b[14]};
               sens_in[4] = |{b[17], b[16]};
            end
         end
         tpu_pkg::LAYOUT_PACKED: begin
            lspeed_in = {b[1], b[0]};
            ldir_in   = b[2];
            rspeed_in = {b[4], b[3]};
            rdir_in   = b[5];
            for (int j = 0; j < tpu_pkg::NUM_SENSORS; j++) begin
               sens_in[j] = pkt_info.reach[j] && (|b[tpu_pkg::PACKED_SENSOR_BASE + j]);
            end
         end
         default: begin
            sens_in = '0;
         end
      endcase
      // rejected packets carry only their status
      if (pkt_info.status != tpu_pkg::STATUS_OK) begin
         lspeed_in = '0;
         ldir_in   = '0;
         rspeed_in = '0;
         rdir_in   = '0;
         sens_in   = '0;
      end
      status_in = pkt_info.status;

      if (pkt_take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_take) begin
         lspeed_ff <= lspeed_in;
         ldir_ff   <= ldir_in;
         rspeed_ff <= rspeed_in;
         rdir_ff   <= rdir_in;
         sens_ff   <= sens_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_left_speed      = $signed(lspeed_ff);
   assign rsp_left_direction  = $signed(ldir_ff);
   assign rsp_right_speed     = $signed(rspeed_ff);
   assign rsp_right_direction = $signed(rdir_ff);
   assign rsp_sensor_a        = sens_ff[0];
   assign rsp_sensor_b        = sens_ff[1];
   assign rsp_sensor_c        = sens_ff[2];
   assign rsp_sensor_d        = sens_ff[3];
   assign rsp_sensor_e        = sens_ff[4];
   assign rsp_packet_status   = status_ff;

endmodule

[test/telemetry_result_checker.sv]
// Checker for the telemetry packet unpacker: mirrors the byte store, predicts and compares results.
`timescale 1ns / 100ps
module telemetry_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [tpu_pkg::ADDR_WIDTH-1:0] csr_write_data,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last_byte,
   input  logic [tpu_pkg::ADDR_WIDTH-1:0] req_sender_address,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic signed [15:0]             rsp_left_speed,
   input  logic signed [7:0]              rsp_left_direction,
   input  logic signed [15:0]             rsp_right_speed,
   input  logic signed [7:0]              rsp_right_direction,
   input  logic                           rsp_sensor_a,
   input  logic                           rsp_sensor_b,
   input  logic                           rsp_sensor_c,
   input  logic                           rsp_sensor_d,
   input  logic                           rsp_sensor_e,
   input  logic [1:0]                     rsp_packet_status,
   output int                             error_count,
   output int                             pending_count,
   output int                             unpacked_count,
   output int                             rejected_count
);
   import tpu_pkg::*;

   localparam int FULL_SENSOR_BASE = 8;

   typedef struct packed {
      logic signed [15:0]     left_speed;
      logic signed [7:0]      left_direction;
      logic signed [15:0]     right_speed;
      logic signed [7:0]      right_direction;
      logic [NUM_SENSORS-1:0] sensors;   // bit 0 is sensor a
      status_type             status;
   } telemetry_type;

   telemetry_type          pending_telemetry[$];
   logic [7:0]             kept_bytes[KEEP_BYTES];
   logic [COUNT_WIDTH-1:0] bytes_in_packet;
   logic [ADDR_WIDTH-1:0]  sender_copy;

   initial begin
      error_count    = 0;
      pending_count  = 0;
      unpacked_count = 0;
      rejected_count = 0;
   end

   function automatic telemetry_type unpack_packet(input int len,
                                                   input logic [ADDR_WIDTH-1:0] src);
      telemetry_type t;
      int s;
      t = '0;
      t.status = STATUS_OK;
      // source is checked before length
      if (src != sender_copy) begin
         t.status = STATUS_WRONG_SOURCE;
      end else if (len < MIN_LEN) begin
         t.status = STATUS_TOO_SHORT;
      end else if (len == FULL_LEN || len == SHORT_LEN) begin
         t.left_speed      = {kept_bytes[1], kept_bytes[0]};
         t.left_direction  = kept_bytes[2];
         t.right_speed     = {kept_bytes[5], kept_bytes[4]};
         t.right_direction = kept_bytes[6];
         for (s = 0; s < NUM_SENSORS; s++) begin
            if (s < 3 || len == FULL_LEN) begin
               t.sensors[s] = {kept_bytes[FULL_SENSOR_BASE + 2*s + 1],
                               kept_bytes[FULL_SENSOR_BASE + 2*s]} != 16'd0;
            end
         end
      end else begin
         t.left_speed      = {kept_bytes[1], kept_bytes[0]};
         t.left_direction  = kept_bytes[2];
         t.right_speed     = {kept_bytes[4], kept_bytes[3]};
         t.right_direction = kept_bytes[5];
         for (s = 0; s < NUM_SENSORS; s++) begin
            if (len > PACKED_SENSOR_BASE + s) begin
               t.sensors[s] = kept_bytes[PACKED_SENSOR_BASE + s] != 8'd0;
            end
         end
      end
      return t;
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      telemetry_type want;
      if (reset) begin
         bytes_in_packet = '0;
         sender_copy     = SENDER_RESET;
         pending_telemetry.delete();
      end else begin
         // results first, so an item taken at this edge cannot match them
         if (rsp_valid && rsp_ready) begin
            if (pending_telemetry.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got status %0d",
                        $time, rsp_packet_status);
            end else begin
               want = pending_telemetry.pop_front();
               check_field("left_speed", want.left_speed, rsp_left_speed);
               check_field("left_direction", want.left_direction, rsp_left_direction);
               check_field("right_speed", want.right_speed, rsp_right_speed);
               check_field("right_direction", want.right_direction, rsp_right_direction);
               check_field("sensor_a", want.sensors[0], rsp_sensor_a);
               check_field("sensor_b", want.sensors[1], rsp_sensor_b);
               check_field("sensor_c", want.sensors[2], rsp_sensor_c);
               check_field("sensor_d", want.sensors[3], rsp_sensor_d);
               check_field("sensor_e", want.sensors[4], rsp_sensor_e);
               check_field("packet_status", want.status, rsp_packet_status);
               if (want.status == STATUS_OK) unpacked_count++;
               else rejected_count++;
            end
         end
         if (req_valid && req_ready) begin
            if (bytes_in_packet < KEEP_BYTES) begin
               kept_bytes[bytes_in_packet[INDEX_WIDTH-1:0]] = req_data_byte;
            end
            if (bytes_in_packet != '1) bytes_in_packet++;
            if (req_last_byte) begin
               pending_telemetry.push_back(unpack_packet(bytes_in_packet, req_sender_address));
               bytes_in_packet = '0;
            end
         end
         if (csr_write_enable) sender_copy = csr_write_data;
      end
      pending_count = pending_telemetry.size();
   end

endmodule

[test/tb.sv]
// Testbench top for the telemetry packet unpacker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
   import tpu_pkg::*;

   localparam int LIMIT        = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 30;

   typedef enum {PAT_RANDOM, PAT_ZERO, PAT_ONES, PAT_SIGN, PAT_MAX, PAT_ODD_ONLY} fill_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [ADDR_WIDTH-1:0]   csr_write_data;
   logic                    req_valid;
   logic                    req_ready;
   logic [7:0]              req_data_byte;
   logic                    req_last_byte;
   logic [ADDR_WIDTH-1:0]   req_sender_address;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [15:0]      rsp_left_speed;
   logic signed [7:0]       rsp_left_direction;
   logic signed [15:0]      rsp_right_speed;
   logic signed [7:0]       rsp_right_direction;
   logic                    rsp_sensor_a;
   logic                    rsp_sensor_b;
   logic                    rsp_sensor_c;
   logic                    rsp_sensor_d;
   logic                    rsp_sensor_e;
   logic [1:0]              rsp_packet_status;

   int                      error_count;
   int                      pending_count;
   int                      unpacked_count;
   int                      rejected_count;

   int                      cycle_count;
   int                      bytes_sent;
   int                      packets_sent;
   int                      burst_left;
   bit                      sender_gaps;
   bit                      hold_wanted;
   bit                      hold_served;
   logic [ADDR_WIDTH-1:0]   active_sender;

   telemetry_packet_unpacker u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .req_sender_address  (req_sender_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_speed      (rsp_left_speed),
      .rsp_left_direction  (rsp_left_direction),
      .rsp_right_speed     (rsp_right_speed),
      .rsp_right_direction (rsp_right_direction),
      .rsp_sensor_a        (rsp_sensor_a),
      .rsp_sensor_b        (rsp_sensor_b),
      .rsp_sensor_c        (rsp_sensor_c),
      .rsp_sensor_d        (rsp_sensor_d),
      .rsp_sensor_e        (rsp_sensor_e),
      .rsp_packet_status   (rsp_packet_status)
   );

   telemetry_result_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .req_sender_address  (req_sender_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_speed      (rsp_left_speed),
      .rsp_left_direction  (rsp_left_direction),
      .rsp_right_speed     (rsp_right_speed),
      .rsp_right_direction (rsp_right_direction),
      .rsp_sensor_a        (rsp_sensor_a),
      .rsp_sensor_b        (rsp_sensor_b),
      .rsp_sensor_c        (rsp_sensor_c),
      .rsp_sensor_d        (rsp_sensor_d),
      .rsp_sensor_e        (rsp_sensor_e),
      .rsp_packet_status   (rsp_packet_status),
      .error_count         (error_count),
      .pending_count       (pending_count),
      .unpacked_count      (unpacked_count),
      .rejected_count      (rejected_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: picks a new stall pattern for each span of random length; one long hold-off on request.
   initial begin
      int mode;
      int span;
      rsp_ready   = 1'b0;
      hold_served = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(negedge clock);
            if (hold_wanted && !hold_served) begin
               hold_served = 1'b1;
               rsp_ready   = 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0:       rsp_ready = 1'b1;
               1:       rsp_ready = $urandom_range(0, 1);
               2:       rsp_ready = $urandom_range(0, 3) == 0;
               default: rsp_ready = ~rsp_ready;
            endcase
         end
      end
   end

   function automatic logic [ADDR_WIDTH-1:0] random_address();
      return {16'($urandom), $urandom};
   endfunction

   function automatic logic [ADDR_WIDTH-1:0] foreign_of(input logic [ADDR_WIDTH-1:0] a);
      logic [ADDR_WIDTH-1:0] r;
      r = random_address();
      if ($urandom_range(0, 1) == 0 || r == a) begin
         r = a ^ (48'd1 << $urandom_range(0, ADDR_WIDTH - 1));
      end
      return r;
   endfunction

   function automatic logic [7:0] pick_byte(input fill_type fill, input int index,
                                            input int zero_pct);
      case (fill)
         PAT_ZERO:     return 8'h00;
         PAT_ONES:     return 8'hFF;
         PAT_SIGN:     return 8'h80;
         PAT_MAX:      return 8'h7F;
         PAT_ODD_ONLY: return index[0] ? 8'($urandom_range(1, 255)) : 8'h00;
         default:      return ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom);
      endcase
   endfunction

   // Sender works in bursts; valid stays up between items of a burst.
   task automatic push_byte(input logic [7:0] b, input logic last,
                            input logic [ADDR_WIDTH-1:0] addr);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid          = 1'b1;
      req_data_byte      = b;
      req_last_byte      = last;
      req_sender_address = addr;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_packet(input int len, input logic [ADDR_WIDTH-1:0] src,
                              input fill_type fill, input int zero_pct);
      logic [ADDR_WIDTH-1:0] addr;
      for (int i = 0; i < len; i++) begin
         // address only counts on the last byte; scramble it elsewhere now and then
         addr = (i == len - 1 || $urandom_range(0, 3) != 0) ? src : random_address();
         push_byte(pick_byte(fill, i, zero_pct), i == len - 1, addr);
      end
      packets_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_sender(input logic [ADDR_WIDTH-1:0] v);
      settle();
      csr_write_enable = 1'b1;
      csr_write_data   = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      active_sender    = v;
   endtask

   initial begin
      int reach_lens[] = '{10, 11, 12, 13, 15, 16, 17, 19};
      int zero_choices[4] = '{0, 20, 50, 80};
      int phase_start;
      int pick;
      int len;
      logic [ADDR_WIDTH-1:0] src;

      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_valid          = 1'b0;
      req_data_byte      = '0;
      req_last_byte      = 1'b0;
      req_sender_address = '0;
      hold_wanted        = 1'b0;
      sender_gaps        = 1'b1;
      burst_left         = 0;
      bytes_sent         = 0;
      packets_sent       = 0;
      active_sender      = SENDER_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed packets, with the expected sender at its default
      send_packet(FULL_LEN, active_sender, PAT_RANDOM, 0);
      send_packet(FULL_LEN, active_sender, PAT_ZERO, 0);
      send_packet(FULL_LEN, active_sender, PAT_ONES, 0);
      send_packet(SHORT_LEN, active_sender, PAT_ONES, 0);
      send_packet(SHORT_LEN, active_sender, PAT_SIGN, 0);
      send_packet(FULL_LEN, active_sender, PAT_ODD_ONLY, 0);
      send_packet(SHORT_LEN, active_sender, PAT_ODD_ONLY, 0);
      send_packet(MIN_LEN, active_sender, PAT_MAX, 0);
      send_packet(MIN_LEN - 1, active_sender, PAT_ONES, 0);
      send_packet(1, active_sender, PAT_ONES, 0);
      foreach (reach_lens[k]) send_packet(reach_lens[k], active_sender, PAT_ONES, 0);
      send_packet(12, active_sender, PAT_ODD_ONLY, 0);
      send_packet(FULL_LEN, foreign_of(active_sender), PAT_ONES, 0);
      send_packet(3, foreign_of(active_sender), PAT_ONES, 0);
      send_packet(40, active_sender, PAT_RANDOM, 30);
      // counter saturation
      send_packet(255, active_sender, PAT_ONES, 0);
      send_packet(256, active_sender, PAT_RANDOM, 50);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       write_sender('0);
            1:       write_sender('1);
            4:       write_sender(SENDER_RESET);
            default: write_sender(random_address());
         endcase
         sender_gaps = phase != 0;
         if (phase == 2) begin
            // receiver holds off while short packets keep coming
            hold_wanted = 1'b1;
            sender_gaps = 1'b0;
            repeat (10) send_packet(MIN_LEN, active_sender, PAT_RANDOM, 20);
            sender_gaps = 1'b1;
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      len = FULL_LEN;
            else if (pick < 60) len = SHORT_LEN;
            else if (pick < 80) len = $urandom_range(MIN_LEN, FULL_LEN - 1);
            else if (pick < 90) len = $urandom_range(1, MIN_LEN - 1);
            else if (pick < 99) len = $urandom_range(FULL_LEN + 1, 40);
            else                len = $urandom_range(250, 270);
            src = ($urandom_range(0, 99) < 85) ? active_sender : foreign_of(active_sender);
            send_packet(len, src, PAT_RANDOM, zero_choices[$urandom_range(0, 3)]);
         end
      end

      settle();
      $display("Run covered %0d bytes in %0d packets: %0d unpacked, %0d rejected.",
               bytes_sent, packets_sent, unpacked_count, rejected_count);
      $display("Sender set to its default, zero, all ones and random values; "
               , "output held off %0d cycles once.", HOLD_CYCLES);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
